// ===== src/mmss_pkg.sv =====
// Package for the minutes:seconds countdown with digit scan.
// Holds the opcode codes, the queue job type, the limits and the decimal split helper.
// Depends on nothing; every other file of the block uses it.
package mmss_pkg;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_ZEROS = 2'd3
   } opcode_type;

   localparam logic [6:0] MAX_MINUTES  = 7'd99;
   localparam logic [5:0] MAX_SECONDS  = 6'd59;
   localparam logic [5:0] LIMIT_RESET  = 6'd50;
   localparam logic [3:0] DIGIT_MAX    = 4'd9;
   localparam logic [3:0] SEC_TENS_MAX = 4'd5;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // Four display positions are scanned per refresh tick.
   localparam int unsigned PHASE_W   = 2;
   localparam logic [PHASE_W-1:0] LAST_PHASE = 2'd3;

   localparam logic [3:0] SEL_ALL_ON = 4'b0000;

   // One queued display job: either a four-digit scan or a single all-zeros result.
   typedef struct packed {
      logic       zeros;
      logic       tout;
      logic [3:0] min_tens;
      logic [3:0] min_ones;
      logic [3:0] sec_tens;
      logic [3:0] sec_ones;
   } job_type;

   // Splits a value below 100 into tens and ones; x*205 >> 11 equals x/10 for x below 1029.
   function automatic logic [7:0] split_dec(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      prod     = 15'(v) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = {tens, 3'b000} - 7'd0 + {2'b00, tens, 1'b0};
      ones     = v - tens_x10;
      return {tens, ones[3:0]};
   endfunction

endpackage

// ===== src/mm_ss_countdown_with_digit_scan_unit.sv =====
// Top level of the minutes:seconds countdown with four-digit display scan.
// Instantiates mmss_front, mmss_queue and mmss_back; uses mmss_pkg.
//
// The block accepts one request per cycle while its job queue has room. Load and
// clear-prescaler requests update the time or prescaler in the front end and give no
// result. A refresh tick queues a scan job that gives four results from the time as it
// stood before the tick; show-zeros gives one result. The output register drains one
// result per cycle while rsp_ready holds, so sustained throughput is one refresh tick per
// four results, set by the single result port; the first result of an idle block passes
// through a queue slot and then the output register. The prescale limit is written through
// the csr channel, which is always ready, and must only be written while the block is idle.
module mm_ss_countdown_with_digit_scan_unit #(
   parameter int unsigned QUEUE_DEPTH = mmss_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [6:0] req_load_minutes,
   input  logic [5:0] req_load_seconds,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_digit_select,
   output logic [3:0] rsp_digit_value,
   output logic       rsp_time_out,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [5:0] csr_prescale_limit
);

   logic              push_en;
   logic              push_ready;
   mmss_pkg::job_type push_job;
   logic              head_valid;
   logic              pop_en;
   mmss_pkg::job_type head_job;

   mmss_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_load_minutes   (req_load_minutes),
      .req_load_seconds   (req_load_seconds),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_prescale_limit (csr_prescale_limit),
      .push_en            (push_en),
      .push_ready         (push_ready),
      .push_job           (push_job)
   );

   mmss_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (push_en),
      .push_ready (push_ready),
      .push_job   (push_job),
      .head_valid (head_valid),
      .pop_en     (pop_en),
      .head_job   (head_job)
   );

   mmss_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop_en           (pop_en),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit_select (rsp_digit_select),
      .rsp_digit_value  (rsp_digit_value),
      .rsp_time_out     (rsp_time_out),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== src/mmss_front.sv =====
// Front end of the countdown: accepts requests, keeps the time and prescaler,
// and pushes display jobs into the queue. Uses mmss_pkg.
module mmss_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [6:0]            req_load_minutes,
   input  logic [5:0]            req_load_seconds,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [5:0]            csr_prescale_limit,
   output logic                  push_en,
   input  logic                  push_ready,
   output mmss_pkg::job_type     push_job
);

   logic [5:0] limit_ff, limit_in;
   logic [5:0] count_ff, count_in;
   logic [3:0] mt_ff, mt_in;
   logic [3:0] mo_ff, mo_in;
   logic [3:0] st_ff, st_in;
   logic [3:0] so_ff, so_in;

   logic       accept;
   logic       tout;
   logic [6:0] min_sat;
   logic [5:0] sec_sat;
   logic [7:0] min_split;
   logic [7:0] sec_split;

   assign req_ready = push_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && push_ready;
   assign tout      = (mt_ff == 4'd0) && (mo_ff == 4'd0) && (st_ff == 4'd0) && (so_ff == 4'd0);

   assign min_sat   = (req_load_minutes > mmss_pkg::MAX_MINUTES) ? mmss_pkg::MAX_MINUTES
                                                                  : req_load_minutes;
   assign sec_sat   = (req_load_seconds > mmss_pkg::MAX_SECONDS) ? mmss_pkg::MAX_SECONDS
                                                                  : req_load_seconds;
   assign min_split = mmss_pkg::split_dec(min_sat);
   assign sec_split = mmss_pkg::split_dec({1'b0, sec_sat});

   always_comb begin
      limit_in = limit_ff;
      count_in = count_ff;
      mt_in    = mt_ff;
      mo_in    = mo_ff;
      st_in    = st_ff;
      so_in    = so_ff;
      push_en  = 1'b0;

      push_job.zeros    = (mmss_pkg::opcode_type'(req_opcode) == mmss_pkg::OP_ZEROS);
      push_job.tout     = tout;
      push_job.min_tens = mt_ff;
      push_job.min_ones = mo_ff;
      push_job.sec_tens = st_ff;
      push_job.sec_ones = so_ff;

      if (csr_valid) begin
         limit_in = csr_prescale_limit;
      end

      if (accept) begin
         unique case (mmss_pkg::opcode_type'(req_opcode))
            mmss_pkg::OP_LOAD: begin
               mt_in = min_split[7:4];
               mo_in = min_split[3:0];
               st_in = sec_split[7:4];
               so_in = sec_split[3:0];
            end
            mmss_pkg::OP_TICK: begin
               push_en = 1'b1;
               if (count_ff == limit_ff) begin
                  // One second elapses; the time holds once it reaches 00:00.
                  if (st_ff == 4'd0 && so_ff == 4'd0) begin
                     if (mt_ff != 4'd0 || mo_ff != 4'd0) begin
                        st_in = mmss_pkg::SEC_TENS_MAX;
                        so_in = mmss_pkg::DIGIT_MAX;
                        if (mo_ff == 4'd0) begin
                           mo_in = mmss_pkg::DIGIT_MAX;
                           mt_in = mt_ff - 4'd1;
                        end else begin
                           mo_in = mo_ff - 4'd1;
                        end
                     end
                  end else if (so_ff == 4'd0) begin
                     so_in = mmss_pkg::DIGIT_MAX;
                     st_in = st_ff - 4'd1;
                  end else begin
                     so_in = so_ff - 4'd1;
                  end
                  count_in = 6'd1;
               end else begin
                  count_in = count_ff + 6'd1;
               end
            end
            mmss_pkg::OP_CLEAR: begin
               count_in = 6'd0;
            end
            mmss_pkg::OP_ZEROS: begin
               push_en = 1'b1;
            end
            default: begin
               push_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= mmss_pkg::LIMIT_RESET;
         count_ff <= 6'd0;
         mt_ff    <= 4'd0;
         mo_ff    <= 4'd0;
         st_ff    <= 4'd0;
         so_ff    <= 4'd0;
      end else begin
         limit_ff <= limit_in;
         count_ff <= count_in;
         mt_ff    <= mt_in;
         mo_ff    <= mo_in;
         st_ff    <= st_in;
         so_ff    <= so_in;
      end
   end

`ifndef ASSERT_OFF
   // The time is always a valid mm:ss value in decimal digits.
   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      (mt_ff <= mmss_pkg::DIGIT_MAX) && (mo_ff <= mmss_pkg::DIGIT_MAX) &&
      (st_ff <= mmss_pkg::SEC_TENS_MAX) && (so_ff <= mmss_pkg::DIGIT_MAX))
      else $error("countdown time left decimal range");
`endif

endmodule

// ===== src/mmss_queue.sv =====
// Short job queue between the front end and the display scanner.
// Register-based ring buffer; uses mmss_pkg for the job type.
module mmss_queue #(
   parameter int unsigned DEPTH = mmss_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_en,
   output logic               push_ready,
   input  mmss_pkg::job_type  push_job,
   output logic               head_valid,
   input  logic               pop_en,
   output mmss_pkg::job_type  head_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   mmss_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;

   assign push_ready = (fill_ff != CNT_W'(DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_en && !pop_en) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_en && !push_en) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("job queue fill count beyond depth");
`endif

endmodule

// ===== src/mmss_back.sv =====
// Display scanner: turns queued jobs into digit results through an output register.
// Uses mmss_pkg for the job type and phase constants.
module mmss_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  mmss_pkg::job_type  head_job,
   output logic               pop_en,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_digit_select,
   output logic [3:0]         rsp_digit_value,
   output logic               rsp_time_out,
   output logic               rsp_last
);

   logic [mmss_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic                         valid_ff, valid_in;
   logic [3:0]                   sel_ff, sel_in;
   logic [3:0]                   value_ff, value_in;
   logic                         tout_ff, tout_in;
   logic                         last_ff, last_in;

   logic out_free;
   logic emit;
   logic is_last;

   assign out_free = !valid_ff || rsp_ready;
   assign emit     = out_free && head_valid;
   assign is_last  = head_job.zeros || (phase_ff == mmss_pkg::LAST_PHASE);
   assign pop_en   = emit && is_last;

   always_comb begin
      phase_in = phase_ff;
      valid_in = valid_ff && !rsp_ready;
      sel_in   = sel_ff;
      value_in = value_ff;
      tout_in  = tout_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         tout_in  = head_job.tout;
         last_in  = is_last;
         phase_in = is_last ? '0 : phase_ff + 1'b1;
         if (head_job.zeros) begin
            sel_in   = mmss_pkg::SEL_ALL_ON;
            value_in = 4'd0;
         end else begin
            // Active-low select walks from minute tens down to second ones.
            sel_in = ~(4'b1000 >> phase_ff);
            case (phase_ff)
               2'd0:    value_in = head_job.min_tens;
               2'd1:    value_in = head_job.min_ones;
               2'd2:    value_in = head_job.sec_tens;
               default: value_in = head_job.sec_ones;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sel_ff   <= sel_in;
      value_ff <= value_in;
      tout_ff  <= tout_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_digit_select = sel_ff;
   assign rsp_digit_value  = value_ff;
   assign rsp_time_out     = tout_ff;
   assign rsp_last         = last_ff;

`ifndef ASSERT_OFF
   // A scan in progress keeps its job at the head of the queue.
   a_scan_holds_job: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != '0) |-> (head_valid && !head_job.zeros))
      else $error("digit scan lost its job mid-scan");

   // Results before the last one of a scan enable exactly one digit.
   a_single_digit: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> ($countones(sel_ff) == 3))
      else $error("non-final scan result enables other than one digit");

   a_last_phase_wrap: assert property (@(posedge clock) disable iff (reset)
      pop_en |=> (phase_ff == '0))
      else $error("scan phase did not restart after a job completed");
`endif

endmodule

// ===== test/mmss_scan_checker.sv =====
// Scoreboard for the minutes:seconds countdown with digit scan.
// Watches the request, result and csr channels and keeps its own copy of the timer.
// Depends on mmss_pkg for the opcode codes and the time limits.
`timescale 1ns / 100ps

module mmss_scan_checker
   import mmss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [6:0]  req_load_minutes,
   input  logic [5:0]  req_load_seconds,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_digit_select,
   input  logic [3:0]  rsp_digit_value,
   input  logic        rsp_time_out,
   input  logic        rsp_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [5:0]  csr_prescale_limit,
   output int unsigned mismatches,
   output int unsigned open_results
);

   typedef struct packed {
      logic [3:0] select;
      logic [3:0] value;
      logic       time_out;
      logic       last;
   } digit_type;

   digit_type   pending_digits[$];
   logic [6:0]  minutes_left;
   logic [5:0]  seconds_left;
   logic [5:0]  prescale_count;
   logic [5:0]  prescale_limit;
   int unsigned errors = 0;

   assign mismatches = errors;

   function automatic digit_type make_digit(input logic [3:0] sel, input int unsigned val,
                                            input logic tout, input logic lst);
      digit_type d;
      d.select   = sel;
      d.value    = val[3:0];
      d.time_out = tout;
      d.last     = lst;
      return d;
   endfunction

   // One second elapses when the prescaler matches the limit; 00:00 holds.
   task automatic advance_prescaler();
      if (prescale_count == prescale_limit) begin
         if (seconds_left == '0) begin
            if (minutes_left != '0) begin
               minutes_left = minutes_left - 7'd1;
               seconds_left = MAX_SECONDS;
            end
         end else begin
            seconds_left = seconds_left - 6'd1;
         end
         prescale_count = '0;
      end
      prescale_count = prescale_count + 6'd1;
   endtask

   task automatic scan_time_digits(input opcode_type op, input logic [6:0] lm,
                                   input logic [5:0] ls);
      logic        tout;
      int unsigned mins;
      int unsigned secs;
      tout = (minutes_left == '0) && (seconds_left == '0);
      mins = 32'(minutes_left);
      secs = 32'(seconds_left);
      case (op)
         OP_LOAD: begin
            minutes_left = (lm > MAX_MINUTES) ? MAX_MINUTES : lm;
            seconds_left = (ls > MAX_SECONDS) ? MAX_SECONDS : ls;
         end
         OP_TICK: begin
            pending_digits.push_back(make_digit(4'b0111, mins / 10, tout, 1'b0));
            pending_digits.push_back(make_digit(4'b1011, mins % 10, tout, 1'b0));
            pending_digits.push_back(make_digit(4'b1101, secs / 10, tout, 1'b0));
            pending_digits.push_back(make_digit(4'b1110, secs % 10, tout, 1'b1));
            advance_prescaler();
         end
         OP_CLEAR: begin
            prescale_count = '0;
         end
         OP_ZEROS: begin
            pending_digits.push_back(make_digit(SEL_ALL_ON, 0, tout, 1'b1));
         end
      endcase
   endtask

   task automatic check_digit(input digit_type got);
      digit_type want;
      if (pending_digits.size() == 0) begin
         if (errors < 10)
            $display("%0t: unexpected result sel=%b val=%0d tout=%b last=%b", $realtime,
                     got.select, got.value, got.time_out, got.last);
         errors++;
      end else begin
         want = pending_digits.pop_front();
         if (got.select != want.select || got.value != want.value ||
             got.time_out != want.time_out || got.last != want.last) begin
            if (errors < 10)
               $display("%0t: result mismatch, expected sel=%b val=%0d tout=%b last=%b,",
                        $realtime, want.select, want.value, want.time_out, want.last,
                        " got sel=%b val=%0d tout=%b last=%b",
                        got.select, got.value, got.time_out, got.last);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         minutes_left   = '0;
         seconds_left   = '0;
         prescale_count = '0;
         prescale_limit = LIMIT_RESET;
         pending_digits.delete();
      end else begin
         if (csr_valid && csr_ready)
            prescale_limit = csr_prescale_limit;
         if (rsp_valid && rsp_ready)
            check_digit({rsp_digit_select, rsp_digit_value, rsp_time_out, rsp_last});
         if (req_valid && req_ready)
            scan_time_digits(opcode_type'(req_opcode), req_load_minutes, req_load_seconds);
      end
      open_results <= pending_digits.size();
   end

endmodule

// ===== test/tb.sv =====
// Top of the testbench for mm_ss_countdown_with_digit_scan_unit.
// Drives requests and csr writes and gives the verdict; mmss_scan_checker does the checking.
// Depends on mmss_pkg, the block and test/mmss_scan_checker.sv.
`timescale 1ns / 100ps

module tb;
   import mmss_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;

   logic        clock;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode         = OP_LOAD;
   logic [6:0]  req_load_minutes   = '0;
   logic [5:0]  req_load_seconds   = '0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b1;
   logic [3:0]  rsp_digit_select;
   logic [3:0]  rsp_digit_value;
   logic        rsp_time_out;
   logic        rsp_last;
   logic        csr_valid          = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_prescale_limit = '0;
   logic        steady             = 1'b0;
   int unsigned mismatches;
   int unsigned open_results;
   int unsigned quiet_cycles       = 0;

   mm_ss_countdown_with_digit_scan_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_load_minutes   (req_load_minutes),
      .req_load_seconds   (req_load_seconds),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digit_select   (rsp_digit_select),
      .rsp_digit_value    (rsp_digit_value),
      .rsp_time_out       (rsp_time_out),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_prescale_limit (csr_prescale_limit)
   );

   mmss_scan_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_load_minutes   (req_load_minutes),
      .req_load_seconds   (req_load_seconds),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digit_select   (rsp_digit_select),
      .rsp_digit_value    (rsp_digit_value),
      .rsp_time_out       (rsp_time_out),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_prescale_limit (csr_prescale_limit),
      .mismatches         (mismatches),
      .open_results       (open_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 10);
   end

   // Any transfer on any channel restarts the count of idle cycles.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Valid is only lowered when a gap is taken, so it never drops and rises in one step.
   task automatic send_item(input opcode_type op, input logic [6:0] lm, input logic [5:0] ls);
      if (!steady && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_load_minutes <= lm;
      req_load_seconds <= ls;
      do @(posedge clock); while (!req_ready);
   endtask

   // Loads and clears give no result, so the task goes on waiting after the last one.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_results != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [5:0] limit);
      drain_results();
      csr_valid          <= 1'b1;
      csr_prescale_limit <= limit;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [5:0] limit, input int unsigned count,
                            input logic no_idle, input int unsigned tick_pct);
      opcode_type  op;
      int unsigned pick;
      logic [6:0]  lm;
      logic [5:0]  ls;
      write_limit(limit);
      steady <= no_idle;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         lm   = 7'($urandom_range(0, 127));
         ls   = 6'($urandom_range(0, 63));
         if (pick < tick_pct) begin
            op = OP_TICK;
         end else begin
            pick = $urandom_range(0, 99);
            op   = (pick < 40) ? OP_LOAD : (pick < 75) ? OP_ZEROS : OP_CLEAR;
         end
         // Loads mostly stay in range; short times let the countdown reach 00:00.
         if (op == OP_LOAD) begin
            pick = $urandom_range(0, 7);
            if (pick < 3) begin
               lm = 7'($urandom_range(0, 2));
               ls = 6'($urandom_range(0, 3));
            end else if (pick < 7) begin
               lm = 7'($urandom_range(0, 99));
               ls = 6'($urandom_range(0, 59));
            end
         end
         send_item(op, lm, ls);
         if ($urandom_range(0, 49) == 0)
            drain_results();
      end
      steady <= 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_limit(6'd1);
      send_item(OP_ZEROS, '0, '0);
      send_item(OP_TICK, '0, '0);
      send_item(OP_LOAD, 7'd127, 6'd63);
      send_item(OP_TICK, '0, '0);
      send_item(OP_ZEROS, '0, '0);
      send_item(OP_LOAD, 7'd99, 6'd59);
      send_item(OP_TICK, '0, '0);
      send_item(OP_LOAD, 7'd100, 6'd60);
      send_item(OP_TICK, '0, '0);
      // A borrow from minutes into seconds.
      send_item(OP_LOAD, 7'd1, 6'd0);
      repeat (3) send_item(OP_TICK, '0, '0);
      // Counting down into 00:00, where the time must hold.
      send_item(OP_LOAD, 7'd0, 6'd1);
      repeat (4) send_item(OP_TICK, '0, '0);
      send_item(OP_CLEAR, '0, '0);
      repeat (2) send_item(OP_TICK, '0, '0);

      run_phase(6'd63, 60, 1'b0, 70);
      // With a limit of 0 the count only matches after it wraps, so ticks dominate.
      run_phase(6'd0, 90, 1'b0, 95);
      run_phase(6'd5, 70, 1'b1, 70);
      run_phase(6'd50, 60, 1'b0, 60);

      drain_results();
      if (mismatches == 0 && open_results == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== sim.f =====
src/mmss_pkg.sv
src/mmss_front.sv
src/mmss_queue.sv
src/mmss_back.sv
src/mm_ss_countdown_with_digit_scan_unit.sv
test/mmss_scan_checker.sv
test/tb.sv
